/* rtl/core/urtoa_pkg.sv */
// Shared types, constants and helpers for the unsigned-to-radix ASCII converter.
`default_nettype none

package urtoa_pkg;

    // Fixed field widths
    localparam int IN_W           = 64;
    localparam int RADIX_W        = 5;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 7;
    localparam int BITS_PER_CYCLE = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // Digit characters "0123456789abcdef"
    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    // Divider control from the sequencer
    typedef struct packed {
        logic load;     // capture a new dividend
        logic run;      // start one digit division
    } div_ctrl_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic               done;       // one-cycle pulse, digit ready
        logic               quot_zero;  // quotient left in the work register is zero
        logic [DIGIT_W-1:0] rem;        // remainder, i.e. the digit
    } div_stat_t;

    // Clamp the programmed base into 2..16
    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    // Digit value to ASCII
    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        return DIGIT_CHARS[d];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/unsigned_to_radix_ascii_top.sv */
// Top level: unsigned value to ASCII digits in a base from 2 to 16, most significant first.
// Each digit is one division by the 8-bit-per-cycle divider; digits are written to the
// digit RAM and read back in reverse through the RAM read port, one read at a time, and a
// read is issued only when the output register is empty or being taken, so output stalls
// hold the read-back. Sequential: a new value is accepted only in idle, which follows the
// issue of the last digit read of the previous item, so conversions do not overlap.
// Reset sets the base to 10 and idles the block; the digit RAM needs no clearing pass.
`default_nettype none

module unsigned_to_radix_ascii_top #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [urtoa_pkg::RADIX_W-1:0]  radix,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [urtoa_pkg::IN_W-1:0]     value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [urtoa_pkg::CHAR_W-1:0]   digit_char,
    output logic                           last_digit
);

    import urtoa_pkg::*;

    localparam int AW    = $clog2(VALUE_WIDTH);
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(VALUE_WIDTH);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

    state_t             state_reg, state_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic [CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               pend_last_reg, pend_last_next;
    logic               out_valid_reg, out_valid_next;
    logic               last_reg, last_next;
    logic [CHAR_W-1:0]  char_reg, char_next;

    div_ctrl_t          div_ctrl;
    div_stat_t          div_stat;
    logic               accept;
    logic               finish;
    logic               issue;
    logic               ram_we;
    logic [CNT_W-1:0]   cnt_inc;
    logic [DIGIT_W-1:0] ram_rdata;

    // Divider
    urtoa_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .value (value),
        .radix (eff_radix(radix_reg)),
        .stat  (div_stat)
    );

    // Digit buffer, least significant digit at entry 0
    urtoa_ram #(
        .WIDTH(DIGIT_W),
        .DEPTH(VALUE_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (dig_cnt_reg[AW-1:0]),
        .wdata (div_stat.rem),
        .re    (issue),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // Handshake and control decode
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign ram_we    = (state_reg == ST_DIV) && div_stat.done;
    assign cnt_inc   = dig_cnt_reg + CNT_W'(1);
    assign finish    = div_stat.quot_zero || (cnt_inc == CNT_MAX);
    assign issue     = (state_reg == ST_EMIT) && !rd_pend_reg
                       && (!out_valid_reg || !out_stall);

    assign div_ctrl.load = accept;
    assign div_ctrl.run  = accept || (ram_we && !finish);

    // Sequencer and output register next values
    always_comb
    begin
        state_next     = state_reg;
        radix_next     = radix_reg;
        dig_cnt_next   = dig_cnt_reg;
        rd_idx_next    = rd_idx_reg;
        rd_pend_next   = issue;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        last_next      = last_reg;
        char_next      = char_reg;

        if (cfg_valid && cfg_ready) begin
            radix_next = radix;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    dig_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done) begin
                    dig_cnt_next = cnt_inc;
                    if (finish) begin
                        rd_idx_next = dig_cnt_reg[AW-1:0];
                        state_next  = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (issue) begin
                    pend_last_next = (rd_idx_reg == '0);
                    rd_idx_next    = rd_idx_reg - AW'(1);
                    if (rd_idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output beat register: load on read return, clear when taken
        if (rd_pend_reg) begin
            out_valid_next = 1'b1;
            last_next      = pend_last_reg;
            char_next      = digit_ascii(ram_rdata);
        end
        else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            dig_cnt_reg   <= '0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            char_reg      <= '0;
        end
        else begin
            state_reg     <= state_next;
            radix_reg     <= radix_next;
            dig_cnt_reg   <= dig_cnt_next;
            rd_idx_reg    <= rd_idx_next;
            rd_pend_reg   <= rd_pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            char_reg      <= char_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

    // Read data only returns into an empty output register
    a_rd_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> !out_valid_reg)
        else $error("digit read returned while output beat still held");

    // Digit buffer is written only during division and only below its depth
    a_wr_div: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_DIV) && (dig_cnt_reg < CNT_MAX))
        else $error("digit buffer written outside division or past its depth");

    // Nothing follows the final digit beat in the very next cycle
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg && !out_stall |=> !out_valid_reg)
        else $error("beat presented right after the final digit");

endmodule

`default_nettype wire

/* rtl/core/urtoa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module urtoa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/urtoa_div.sv */
// Iterative divider: divides the work register by the base, 8 quotient bits per cycle.
`default_nettype none

module urtoa_div #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  urtoa_pkg::div_ctrl_t             ctrl,
    input  logic [urtoa_pkg::IN_W-1:0]       value,
    input  logic [urtoa_pkg::RADIX_W-1:0]    radix,
    output urtoa_pkg::div_stat_t             stat
);

    import urtoa_pkg::*;

    localparam int DW     = ((VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE) * BITS_PER_CYCLE;
    localparam int STEPS  = DW / BITS_PER_CYCLE;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

    logic [DW-1:0]      work_reg, work_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [DW-1:0]      w_step;
    logic [RADIX_W-1:0] r_step;

    // Eight restoring long-division steps; quotient bits shift into the work register
    always_comb
    begin
        logic [RADIX_W-1:0] r;
        logic [DW-1:0]      w;
        logic               q;
        r = {1'b0, rem_reg};
        w = work_reg;
        for (int i = 0; i < BITS_PER_CYCLE; i++) begin
            r = {r[DIGIT_W-1:0], w[DW-1]};
            q = (r >= radix);
            if (q) begin
                r = r - radix;
            end
            w = {w[DW-2:0], q};
        end
        w_step = w;
        r_step = r;
    end

    // Next-state logic
    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.load) begin
            work_next = '0;
            work_next[VALUE_WIDTH-1:0] = value[VALUE_WIDTH-1:0];
        end
        if (ctrl.run) begin
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg) begin
            work_next = w_step;
            rem_next  = r_step[DIGIT_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign stat.done      = done_reg;
    assign stat.quot_zero = (work_reg == '0);
    assign stat.rem       = rem_reg;

endmodule

`default_nettype wire

/* verif/tb_unsigned_to_radix_ascii_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the unsigned-to-radix ASCII converter top level.
module tb_unsigned_to_radix_ascii_top;
    import urtoa_pkg::*;

    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 40;
    localparam int ITEMS_PER_PHASE = 9;
    localparam int PHASES_PER_MIX  = 4;
    localparam int MAX_DIGITS      = 64;
    localparam int MAX_REPORTS     = 40;

    // One expected digit beat
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } digit_t;

    // Directed row: a base write, or a value with its digits typed in ("" = predicted)
    typedef struct {
        bit                 is_cfg;
        logic [RADIX_W-1:0] base;
        logic [IN_W-1:0]    num;
        string              digits;
    } plan_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [RADIX_W-1:0] radix;
    logic               in_valid;
    logic               in_stall;
    logic [IN_W-1:0]    value;
    logic               out_valid;
    logic               out_stall;
    logic [CHAR_W-1:0]  digit_char;
    logic               last_digit;

    // Predictor copy of the base register and the digits still owed
    logic [RADIX_W-1:0] base_reg;
    digit_t             pending_digits [$];

    int cycle_count    = 0;
    int mismatches     = 0;
    int digits_checked = 0;
    int values_sent    = 0;
    int base_writes    = 0;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int hold_requests  = 0;
    int hold_served    = 0;

    plan_row_t directed_plan [] = '{
        '{1'b0, 5'd0,  64'd0,                  "0"},
        '{1'b0, 5'd0,  64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615"},
        '{1'b0, 5'd0,  64'd9,                  "9"},
        '{1'b0, 5'd0,  64'd10,                 "10"},
        '{1'b0, 5'd0,  64'd1234567890,         ""},
        '{1'b1, 5'd0,  64'd0,                  ""},
        '{1'b0, 5'd0,  64'd0,                  "0"},
        '{1'b0, 5'd0,  64'd5,                  "101"},
        '{1'b0, 5'd0,  64'hFFFF_FFFF_FFFF_FFFF, ""},
        '{1'b0, 5'd0,  64'h8000_0000_0000_0000, ""},
        '{1'b1, 5'd1,  64'd0,                  ""},
        '{1'b0, 5'd0,  64'd6,                  "110"},
        '{1'b1, 5'd16, 64'd0,                  ""},
        '{1'b0, 5'd0,  64'hFFFF_FFFF_FFFF_FFFF, "ffffffffffffffff"},
        '{1'b0, 5'd0,  64'h0123_4567_89AB_CDEF, "123456789abcdef"},
        '{1'b0, 5'd0,  64'd15,                 "f"},
        '{1'b1, 5'd31, 64'd0,                  ""},
        '{1'b0, 5'd0,  64'd255,                "ff"},
        '{1'b0, 5'd0,  64'hDEAD_BEEF,          "deadbeef"},
        '{1'b1, 5'd17, 64'd0,                  ""},
        '{1'b0, 5'd0,  64'd171,                "ab"},
        '{1'b1, 5'd3,  64'd0,                  ""},
        '{1'b0, 5'd0,  64'd2,                  "2"},
        '{1'b0, 5'd0,  64'd3,                  "10"},
        '{1'b0, 5'd0,  64'hFFFF_FFFF_FFFF_FFFF, ""},
        '{1'b1, 5'd7,  64'd0,                  ""},
        '{1'b0, 5'd0,  64'd823543,             ""}
    };

    // Base per random phase: clamped codes, both ends of the legal range, odd bases
    logic [RADIX_W-1:0] base_plan [12] = '{
        5'd2, 5'd16, 5'd0, 5'd31, 5'd10, 5'd17, 5'd1, 5'd8, 5'd3, 5'd7, 5'd13, 5'd5
    };

    unsigned_to_radix_ascii_top #(
        .VALUE_WIDTH (64)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .radix      (radix),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    always #1 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d digits still owed",
                     cycle_count, pending_digits.size());
            $display("** unsigned_to_radix_ascii_top: FAILED **");
            $finish;
        end
    end

    task automatic log_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
        begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Base 0/1 act as 2, 17..31 act as 16
    function automatic logic [RADIX_W-1:0] clamped_base();
        if (base_reg < 5'd2)
        begin
            return 5'd2;
        end
        if (base_reg > 5'd16)
        begin
            return 5'd16;
        end
        return base_reg;
    endfunction

    // Divide down by the base, then queue the digits most significant first
    function automatic void predict_digits(input logic [IN_W-1:0] num);
        logic [IN_W-1:0]   rest;
        logic [IN_W-1:0]   b;
        logic [3:0]        rem_digits [MAX_DIGITS];
        logic [CHAR_W-1:0] code;
        int                n;
        b = IN_W'(clamped_base());
        rest = num;
        n = 0;
        do
        begin
            rem_digits[n] = 4'(rest % b);
            rest = rest / b;
            n++;
        end
        while (rest != 0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--)
        begin
            if (rem_digits[k] < 4'd10)
            begin
                code = 7'h30 + CHAR_W'(rem_digits[k]);
            end
            else
            begin
                code = 7'h61 + CHAR_W'(rem_digits[k]) - 7'd10;
            end
            pending_digits.push_back('{code, k == 0});
        end
    endfunction

    // Typed-in expectation: one beat per character
    function automatic void queue_digit_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            pending_digits.push_back('{CHAR_W'(s[i]), i == s.len() - 1});
        end
    endfunction

    // Random value: full range, shifted down, tiny, near a power of the base, all 0/1
    function automatic logic [IN_W-1:0] pick_value();
        logic [IN_W-1:0] p;
        logic [IN_W-1:0] b;
        int              sel;
        b = IN_W'(clamped_base());
        sel = $urandom_range(99);
        p = {$urandom, $urandom};
        if (sel < 30)
        begin
            return p;
        end
        if (sel < 60)
        begin
            return p >> $urandom_range(63);
        end
        if (sel < 75)
        begin
            return IN_W'($urandom_range(40));
        end
        if (sel < 95)
        begin
            p = IN_W'(1);
            repeat ($urandom_range(1, 64))
            begin
                if (p <= 64'hFFFF_FFFF_FFFF_FFFF / b)
                begin
                    p = p * b;
                end
            end
            return p - IN_W'($urandom_range(1));
        end
        return sel[0] ? '1 : '0;
    endfunction

    // Offer one value beat; entered and left at a falling edge
    task automatic send_value(input logic [IN_W-1:0] num);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            value    <= {$urandom, $urandom};
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= num;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        values_sent++;
        @(negedge clk);
    endtask

    // Base write only once every owed digit has come back
    task automatic write_radix(input logic [RADIX_W-1:0] r);
        in_valid <= 1'b0;
        while (pending_digits.size() != 0)
        begin
            @(negedge clk);
        end
        cfg_valid <= 1'b1;
        radix     <= r;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        base_reg = r;
        base_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stall, plus a long hold whenever one is requested
    initial
    begin : rx_side
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // Digit beat checker
    always @(posedge clk)
    begin : digit_check
        digit_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            digits_checked++;
            if (pending_digits.size() == 0)
            begin
                log_mismatch($sformatf("digit 0x%02h last=%0b with nothing owed",
                                       digit_char, last_digit));
            end
            else
            begin
                want = pending_digits.pop_front();
                if (digit_char !== want.code)
                begin
                    log_mismatch($sformatf("digit_char 0x%02h, want 0x%02h",
                                           digit_char, want.code));
                end
                if (last_digit !== want.is_last)
                begin
                    log_mismatch($sformatf("last_digit %0b, want %0b",
                                           last_digit, want.is_last));
                end
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        logic [IN_W-1:0] num;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        radix       = RADIX_RESET;
        in_valid    = 1'b0;
        value       = '0;
        base_reg    = RADIX_RESET;
        tx_idle_pct = 14;
        rx_idle_pct = 52;
        repeat (9)
        begin
            @(negedge clk);
        end
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, starting from the reset base
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_cfg)
            begin
                write_radix(directed_plan[i].base);
            end
            else
            begin
                if (directed_plan[i].digits.len() == 0)
                begin
                    predict_digits(directed_plan[i].num);
                end
                else
                begin
                    queue_digit_text(directed_plan[i].digits);
                end
                send_value(directed_plan[i].num);
            end
        end

        // Random part: three idle mixes, four bases each
        for (int mix = 0; mix < 3; mix++)
        begin
            tx_idle_pct = (mix == 0) ? 14 : (mix == 1) ? 52 : 0;
            rx_idle_pct = (mix == 0) ? 52 : (mix == 1) ? 14 : 0;
            for (int ph = 0; ph < PHASES_PER_MIX; ph++)
            begin
                write_radix(base_plan[mix * PHASES_PER_MIX + ph]);
                // long output hold while values keep coming
                if (mix == 2 && ph == 0)
                begin
                    hold_requests++;
                end
                repeat (ITEMS_PER_PHASE)
                begin
                    num = pick_value();
                    predict_digits(num);
                    send_value(num);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_digits.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(negedge clk);
        end

        $display("Converted %0d values into %0d checked digits over %0d base writes,",
                 values_sent, digits_checked, base_writes);
        $display("incl. clamped base codes, both idle mixes, back-to-back and a %0d-cycle hold.",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending_digits.size() == 0)
        begin
            $display("** unsigned_to_radix_ascii_top: PASSED **");
        end
        else
        begin
            $display("** unsigned_to_radix_ascii_top: FAILED **");
        end
        $finish;
    end

endmodule

/* unsigned_to_radix_ascii_top.f */
rtl/core/urtoa_pkg.sv
rtl/core/urtoa_ram.sv
rtl/core/urtoa_div.sv
rtl/core/unsigned_to_radix_ascii_top.sv
verif/tb_unsigned_to_radix_ascii_top.sv
